>>> hdl/wolc_pkg.sv
// Package for the wavetable oscillator core: widths, register codes and
// the sample RAM port structs. Used by every file under hdl.
package wolc_pkg;

	localparam int NUM_TABLES  = 8;
	localparam int TABLE_DEPTH = 2048;
	localparam int TBL_W       = $clog2(NUM_TABLES);
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int ADDR_W      = TBL_W + IDX_W;
	localparam int RAM_DEPTH   = NUM_TABLES * TABLE_DEPTH;

	localparam int SAMPLE_W    = 16;
	localparam int FRAC_W      = 16;
	localparam int PHASE_W     = 43;
	localparam int PFRAC_W     = 32;
	localparam int PINT_W      = PHASE_W - PFRAC_W;
	localparam int LEN_W       = 12;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 43;

	localparam int OUT_DEPTH   = 8;
	localparam int OPTR_W      = $clog2(OUT_DEPTH);
	localparam int OCNT_W      = OPTR_W + 1;

	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(TABLE_DEPTH);
	localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PHASE_INC = 1'b0,
		CFG_SAMPLES   = 1'b1
	} cfg_reg_t;

	// sample RAM write port
	typedef struct packed {
		logic                en;
		logic [ADDR_W-1:0]   addr;
		logic [SAMPLE_W-1:0] data;
	} ram_wr_t;

	// sample RAM read addresses, both read every cycle
	typedef struct packed {
		logic [ADDR_W-1:0] addr_a;
		logic [ADDR_W-1:0] addr_b;
	} ram_rd_t;

	// One step of restoring modulo: shift in one dividend bit, subtract once.
	function automatic logic [IDX_W-1:0] mod_step(
		input logic [IDX_W-1:0] rem,
		input logic             din,
		input logic [LEN_W-1:0] len
	);
		logic [LEN_W-1:0] t;
		logic [LEN_W-1:0] r;
		t = {rem, din};
		r = (t >= len) ? (t - len) : t;
		return r[IDX_W-1:0];
	endfunction

endpackage

>>> hdl/wolc_wave_ram.sv
// Sample table RAM: one write port, two read ports with registered data.
// Depends on wolc_pkg for widths and the port structs.
module wolc_wave_ram
	import wolc_pkg::*;
(
	input  logic                clk,
	input  ram_wr_t             wr,
	input  ram_rd_t             rd,
	output logic [SAMPLE_W-1:0] rd_data_a,
	output logic [SAMPLE_W-1:0] rd_data_b
);

	logic [SAMPLE_W-1:0] mem [RAM_DEPTH];

	// write one sample
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// read both neighbors every cycle
	always_ff @(posedge clk) begin
		rd_data_a <= mem[rd.addr_a];
		rd_data_b <= mem[rd.addr_b];
	end

endmodule

>>> hdl/wolc_out_fifo.sv
// Small output queue for finished samples, sized to cover the pipeline.
// Depends on wolc_pkg for depth and widths.
module wolc_out_fifo
	import wolc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [SAMPLE_W-1:0] push_data,
	output logic                tvalid,
	input  logic                tready,
	output logic [SAMPLE_W-1:0] tdata
);

	logic [SAMPLE_W-1:0] buf_q [OUT_DEPTH];
	logic [OPTR_W-1:0]   wr_ptr_q;
	logic [OPTR_W-1:0]   rd_ptr_q;
	logic [OCNT_W-1:0]   cnt_q;
	logic                do_push;
	logic                do_pop;

	assign tvalid  = (cnt_q != '0);
	assign tdata   = buf_q[rd_ptr_q];
	assign do_pop  = tvalid && tready;
	assign do_push = push && (cnt_q != OCNT_W'(OUT_DEPTH));

	// store pushed samples
	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + OPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + OPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + OCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - OCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> hdl/wavetable_oscillator_lerp_core.sv
// Wavetable oscillator with linear interpolation (top level; uses wolc_pkg,
// wolc_wave_ram and wolc_out_fifo). Eight tables of 2048 16-bit samples sit
// in one RAM with a write port and two registered read ports; the phase is a
// 43-bit 11.32 accumulator. A write item (tuser action 0) stores one sample
// and gives nothing back; a tick (action 1) returns one blended sample and
// advances the phase. The block takes one item per clock: the phase update
// is a single add and compare, the phase-index modulo the table length is
// spread over three stages, the RAM is accessed in the fourth, the multiply
// in the fifth, and the result is registered in the sixth, then enters an
// 8-entry output queue. Writes travel the same stages, so RAM accesses
// keep item order. Input is held off only while eight results are owed.
// Table contents are undefined after reset; no clearing pass is run.
module wavetable_oscillator_lerp_core
	import wolc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,  // [10:0] sample_pos, [26:11] sample_value
	input  logic [3:0]            s_tuser,  // [0] action, [3:1] table_select
	// output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata   // [15:0] sample_out
);

	typedef struct packed {
		logic                tick;
		logic [TBL_W-1:0]    tbl;
		logic [IDX_W-1:0]    pos;
		logic [SAMPLE_W-1:0] val;
		logic [FRAC_W-1:0]   frac;
	} item_t;

	// configuration and phase
	logic [PHASE_W-1:0] inc_q;
	logic [LEN_W-1:0]   len_q;
	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W:0]   phase_sum;
	logic [LEN_W-1:0]   sum_int;
	logic [PHASE_W-1:0] phase_next;

	// pipeline
	logic               s_xfer;
	logic               tick_in;
	item_t              item_in;
	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	item_t              it_s1, it_s2, it_s3, it_s4;
	logic [PINT_W-1:0]  pint_s1, pint_s2, pint_s3;
	logic [IDX_W-1:0]   rem_s2, rem_s3, rem_s4;
	logic [IDX_W-1:0]   rem1_c, rem2_c, rem3_c;
	logic [LEN_W-1:0]   idx1_sum;
	logic [IDX_W-1:0]   idx1_c;
	logic               tk_s5, tk_s6;
	logic [FRAC_W-1:0]  frac_s5;
	logic [SAMPLE_W-1:0] a_s6;
	logic [SAMPLE_W-1:0] lerp_s6;
	logic signed [SAMPLE_W:0]    diff_c;
	logic signed [2*SAMPLE_W+1:0] prod_c;
	logic [SAMPLE_W-1:0] a_rd, b_rd;
	ram_wr_t            ram_wr;
	ram_rd_t            ram_rd;

	// results owed
	logic [OCNT_W-1:0]  pend_q;
	logic               m_xfer;

	// ---------------------------------------------------------------
	// configuration writes; length is stored already clamped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q <= '0;
			len_q <= LEN_MAX;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_PHASE_INC: inc_q <= cfg_data[PHASE_W-1:0];
				CFG_SAMPLES: begin
					if (cfg_data[LEN_W-1:0] == '0) begin
						len_q <= LEN_MIN;
					end else if (cfg_data[LEN_W-1:0] > LEN_MAX) begin
						len_q <= LEN_MAX;
					end else begin
						len_q <= cfg_data[LEN_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// accept and advance phase on each tick transfer
	assign s_tready = (pend_q < OCNT_W'(OUT_DEPTH));
	assign s_xfer   = s_tvalid && s_tready;
	assign tick_in  = s_tuser[0];

	assign phase_sum = {1'b0, phase_q} + {1'b0, inc_q};
	assign sum_int   = phase_sum[PHASE_W:PFRAC_W];
	always_comb begin
		phase_next = phase_sum[PHASE_W-1:0];
		if (sum_int >= len_q) begin
			phase_next[PHASE_W-1:PFRAC_W] = 11'(sum_int - len_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (s_xfer && tick_in) begin
			phase_q <= phase_next;
		end
	end

	always_comb begin
		item_in.tick = tick_in;
		item_in.tbl  = s_tuser[TBL_W:1];
		item_in.pos  = s_tdata[IDX_W-1:0];
		item_in.val  = s_tdata[IDX_W+SAMPLE_W-1:IDX_W];
		item_in.frac = phase_q[PFRAC_W-1:PFRAC_W-FRAC_W];
	end

	// ---------------------------------------------------------------
	// phase index modulo length: four, four, then three bits
	always_comb begin
		rem1_c = '0;
		for (int i = 0; i < 4; i++) begin
			rem1_c = mod_step(rem1_c, pint_s1[PINT_W-1-i], len_q);
		end
		rem2_c = rem_s2;
		for (int i = 0; i < 4; i++) begin
			rem2_c = mod_step(rem2_c, pint_s2[PINT_W-5-i], len_q);
		end
		rem3_c = rem_s3;
		for (int i = 0; i < 3; i++) begin
			rem3_c = mod_step(rem3_c, pint_s3[PINT_W-9-i], len_q);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= s_xfer;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		it_s1   <= item_in;
		pint_s1 <= phase_q[PHASE_W-1:PFRAC_W];
		it_s2   <= it_s1;
		pint_s2 <= pint_s1;
		rem_s2  <= rem1_c;
		it_s3   <= it_s2;
		pint_s3 <= pint_s2;
		rem_s3  <= rem2_c;
		it_s4   <= it_s3;
		rem_s4  <= rem3_c;
		tk_s5   <= it_s4.tick;
		frac_s5 <= it_s4.frac;
		tk_s6   <= tk_s5;
		a_s6    <= a_rd;
		lerp_s6 <= prod_c[PFRAC_W-1:FRAC_W];
	end

	// ---------------------------------------------------------------
	// RAM access in stage four: write item or neighbor read
	assign idx1_sum = {1'b0, rem_s4} + LEN_W'(1);
	assign idx1_c   = (idx1_sum == len_q) ? '0 : idx1_sum[IDX_W-1:0];

	always_comb begin
		ram_wr.en     = v_s4 && !it_s4.tick &&
		                ({1'b0, it_s4.pos} < (IDX_W+1)'(TABLE_DEPTH));
		ram_wr.addr   = {it_s4.tbl, it_s4.pos};
		ram_wr.data   = it_s4.val;
		ram_rd.addr_a = {it_s4.tbl, rem_s4};
		ram_rd.addr_b = {it_s4.tbl, idx1_c};
	end

	wolc_wave_ram u_ram (
		.clk       (clk),
		.wr        (ram_wr),
		.rd        (ram_rd),
		.rd_data_a (a_rd),
		.rd_data_b (b_rd)
	);

	// signed difference times fraction; only bits 31..16 matter modulo 2^16
	assign diff_c = $signed({1'b0, b_rd}) - $signed({1'b0, a_rd});
	assign prod_c = diff_c * $signed({1'b0, frac_s5});

	// ---------------------------------------------------------------
	// output queue and results owed
	assign m_xfer = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({s_xfer && tick_in, m_xfer})
				2'b10:   pend_q <= pend_q + OCNT_W'(1);
				2'b01:   pend_q <= pend_q - OCNT_W'(1);
				default: pend_q <= pend_q;
			endcase
		end
	end

	wolc_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s6 && tk_s6),
		.push_data (a_s6 + lerp_s6),
		.tvalid    (m_tvalid),
		.tready    (m_tready),
		.tdata     (m_tdata)
	);

	// ---------------------------------------------------------------
	// checks
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= OCNT_W'(OUT_DEPTH))
		else $error("results owed exceed output queue depth");

	a_out_owed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (pend_q != '0))
		else $error("output valid with no result owed");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && it_s4.tick) |-> (({1'b0, rem_s4} < len_q) && ({1'b0, idx1_c} < len_q)))
		else $error("table index not reduced below length");

	a_tick_push: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !it_s4.tick) |-> ##2 !(v_s6 && tk_s6))
		else $error("write item produced a result");

endmodule

>>> sim/wavetable_oscillator_lerp_core_tb.sv
// Self-checking testbench for wavetable_oscillator_lerp_core: directed rows, then
// random register settings with targeted sample writes and ticks.
// Depends on wolc_pkg and the core RTL only.
module wavetable_oscillator_lerp_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wolc_pkg::*;

	localparam logic ACT_WRITE    = 1'b0;
	localparam logic ACT_TICK     = 1'b1;
	localparam int   CYCLE_LIMIT  = 200000;
	localparam int   DRAIN_CYCLES = 12;
	localparam int   MAX_SHOWN    = 10;
	localparam int   PHASE_ITEMS  = 134;
	localparam int   HOLD_CYCLES  = 300;
	localparam int   GAP_PCT      = 24;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [31:0]           s_tdata;  // [10:0] sample_pos, [26:11] sample_value
	logic [3:0]            s_tuser;  // [0] action, [3:1] table_select
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [15:0]           m_tdata;  // [15:0] sample_out

	// shadow of the oscillator: tables, phase and registers
	logic [SAMPLE_W-1:0] wave_mem [NUM_TABLES][TABLE_DEPTH];
	bit                  filled   [NUM_TABLES][TABLE_DEPTH];
	logic [PHASE_W-1:0]  phase;
	logic [PHASE_W-1:0]  step;
	logic [LEN_W-1:0]    len_reg;

	logic [SAMPLE_W-1:0] sample_q [$];
	logic [SAMPLE_W-1:0] want;
	int                  fail_cnt = 0;
	int                  writes_sent = 0;
	int                  ticks_sent = 0;
	int                  reg_writes = 0;
	int                  cycles = 0;
	int                  hold_left = 0;
	bit                  no_gaps = 1'b0;
	int                  hold_reqs = 0;
	int                  hold_done = 0;

	typedef struct {
		bit                    is_cfg;
		cfg_reg_t              reg_sel;
		logic [CFG_DATA_W-1:0] reg_val;
		logic                  act;
		logic [TBL_W-1:0]      tbl;
		logic [IDX_W-1:0]      idx;
		logic [SAMPLE_W-1:0]   val;
		bit                    known;
		logic [SAMPLE_W-1:0]   known_out;
	} dir_row_t;

	dir_row_t rows [$];

	wavetable_oscillator_lerp_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// clamp the length register to 1 .. TABLE_DEPTH
	function automatic logic [LEN_W-1:0] active_len();
		if (len_reg == '0) return LEN_MIN;
		if (len_reg > LEN_MAX) return LEN_MAX;
		return len_reg;
	endfunction

	// positions of the two samples a tick would read now
	task automatic tap_positions(output logic [IDX_W-1:0] i0, output logic [IDX_W-1:0] i1);
		logic [LEN_W-1:0] n;
		logic [LEN_W-1:0] nxt;
		n = active_len();
		i0 = IDX_W'({1'b0, phase[PHASE_W-1:PFRAC_W]} % n);
		nxt = {1'b0, i0} + 1'b1;
		if (nxt >= n) nxt = '0;
		i1 = nxt[IDX_W-1:0];
	endtask

	// a + floor((b - a) * f / 2^16), modulo 2^16
	function automatic logic [SAMPLE_W-1:0] blend(logic [SAMPLE_W-1:0] a,
			logic [SAMPLE_W-1:0] b, logic [FRAC_W-1:0] f);
		logic signed [17:0] diff;
		logic signed [34:0] prod;
		logic signed [34:0] q;
		diff = $signed({2'b00, b}) - $signed({2'b00, a});
		prod = diff * $signed({1'b0, f});
		q = prod >>> FRAC_W;
		return a + q[SAMPLE_W-1:0];
	endfunction

	// emit the blended sample, then advance the phase with one wrap at most
	task automatic run_tick(input logic [TBL_W-1:0] tbl, output logic [SAMPLE_W-1:0] s);
		logic [IDX_W-1:0] i0;
		logic [IDX_W-1:0] i1;
		logic [PHASE_W:0] nxt;
		logic [PHASE_W:0] lim;
		tap_positions(i0, i1);
		s = blend(wave_mem[tbl][i0], wave_mem[tbl][i1], phase[PFRAC_W-1:PFRAC_W-FRAC_W]);
		lim = {active_len(), {PFRAC_W{1'b0}}};
		nxt = {1'b0, phase} + {1'b0, step};
		if (nxt >= lim) nxt = nxt - lim;
		phase = nxt[PHASE_W-1:0];
	endtask

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic add_item(logic act, logic [TBL_W-1:0] tbl, logic [IDX_W-1:0] idx,
			logic [SAMPLE_W-1:0] val, bit known, logic [SAMPLE_W-1:0] known_out);
		dir_row_t r;
		r = '{default: '0, reg_sel: CFG_PHASE_INC};
		r.act = act;
		r.tbl = tbl;
		r.idx = idx;
		r.val = val;
		r.known = known;
		r.known_out = known_out;
		rows.push_back(r);
	endtask

	task automatic add_cfg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] val);
		dir_row_t r;
		r = '{default: '0, reg_sel: CFG_PHASE_INC};
		r.is_cfg = 1'b1;
		r.reg_sel = sel;
		r.reg_val = val;
		rows.push_back(r);
	endtask

	task automatic note_mismatch(string what, logic [SAMPLE_W-1:0] e, logic [SAMPLE_W-1:0] a);
		fail_cnt++;
		if (fail_cnt <= MAX_SHOWN)
			$display("MISMATCH at cycle %0d: %s expected %h got %h", cycles, what, e, a);
	endtask

	// offer one item, hold it until the transfer, then update the shadow
	task automatic offer(logic act, logic [TBL_W-1:0] tbl, logic [IDX_W-1:0] idx,
			logic [SAMPLE_W-1:0] val, bit known, logic [SAMPLE_W-1:0] known_out);
		logic [SAMPLE_W-1:0] s;
		while (!no_gaps && $urandom_range(99) < GAP_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= 32'({val, idx});
		s_tuser  <= {tbl, act};
		do @(posedge clk); while (!s_tready);
		if (act == ACT_WRITE) begin
			wave_mem[tbl][idx] = val;
			filled[tbl][idx] = 1'b1;
			writes_sent++;
		end else begin
			run_tick(tbl, s);
			sample_q.push_back(known ? known_out : s);
			ticks_sent++;
		end
	endtask

	// drop valid, wait for every owed sample and for trailing writes to retire
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sample_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		@(posedge clk);
		if (sel == CFG_PHASE_INC) step = val[PHASE_W-1:0];
		else len_reg = val[LEN_W-1:0];
		reg_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// mostly ticks on filled taps; writes aimed at the taps, plus stray writes
	task automatic random_phase(int n, bit squeeze);
		logic [IDX_W-1:0] i0;
		logic [IDX_W-1:0] i1;
		logic [LEN_W-1:0] n_len;
		logic [TBL_W-1:0] tb;
		logic [TBL_W-1:0] tt;
		int               pick;
		bit               found;
		for (int k = 0; k < n; k++) begin
			if (squeeze && k == n / 3) hold_reqs++;
			tap_positions(i0, i1);
			n_len = active_len();
			pick = $urandom_range(99);
			tb = TBL_W'($urandom_range(NUM_TABLES - 1));
			if (pick < 60) begin
				found = 1'b0;
				for (int j = 0; j < NUM_TABLES && !found; j++) begin
					tt = TBL_W'((tb + j) % NUM_TABLES);
					if (filled[tt][i0] && filled[tt][i1]) begin
						found = 1'b1;
						tb = tt;
					end
				end
				if (found)
					offer(ACT_TICK, tb, IDX_W'($urandom), SAMPLE_W'($urandom), 1'b0, '0);
				else
					offer(ACT_WRITE, tb, filled[tb][i0] ? i1 : i0, rand_sample(), 1'b0, '0);
			end else if (pick < 80) begin
				offer(ACT_WRITE, tb, IDX_W'(({1'b0, i0} + $urandom_range(3)) % n_len),
					rand_sample(), 1'b0, '0);
			end else begin
				offer(ACT_WRITE, tb, IDX_W'($urandom_range(TABLE_DEPTH - 1)), rand_sample(),
					1'b0, '0);
			end
		end
	endtask

	// receiver: random back-pressure, one long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_done != hold_reqs) begin
			hold_done = hold_reqs;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (no_gaps) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= GAP_PCT);
		end
	end

	// check each output transfer against the oldest owed sample
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (sample_q.size() == 0) begin
				note_mismatch("output with nothing owed,", 'x, m_tdata);
			end else begin
				want = sample_q.pop_front();
				if (m_tdata !== want) note_mismatch("sample_out", want, m_tdata);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d samples still owed", cycles, sample_q.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		logic [63:0]           r64;
		logic [CFG_DATA_W-1:0] inc_v;
		logic [CFG_DATA_W-1:0] len_v;
		arst_n    = 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_PHASE_INC;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		phase   = '0;
		step    = '0;
		len_reg = LEN_MAX;
		for (int t = 0; t < NUM_TABLES; t++)
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				filled[t][i] = 1'b0;
				wave_mem[t][i] = '0;
			end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: value and index extremes in tables 0 and 7
		add_item(ACT_WRITE, 0, 0, 16'h0000, 0, '0);
		add_item(ACT_WRITE, 0, 1, 16'hFFFF, 0, '0);
		add_item(ACT_WRITE, 0, 2, 16'h8000, 0, '0);
		add_item(ACT_WRITE, 0, 2047, 16'hFFFF, 0, '0);
		add_item(ACT_WRITE, 7, 0, 16'hFFFF, 0, '0);
		add_item(ACT_WRITE, 7, 1, 16'h0000, 0, '0);
		add_item(ACT_WRITE, 7, 2, 16'h0001, 0, '0);
		add_item(ACT_WRITE, 7, 2047, 16'h0000, 0, '0);
		// reset registers: zero step, phase stays at zero
		add_item(ACT_TICK, 0, 0, 0, 1, 16'h0000);
		add_item(ACT_TICK, 7, 0, 0, 1, 16'hFFFF);
		// half-sample step: full-scale rise and fall
		add_cfg(CFG_PHASE_INC, 43'h000_8000_0000);
		add_item(ACT_TICK, 0, 0, 0, 1, 16'h0000);
		add_item(ACT_TICK, 7, 0, 0, 0, '0);
		add_item(ACT_TICK, 0, 0, 0, 1, 16'hFFFF);
		add_item(ACT_TICK, 7, 0, 0, 0, '0);
		// length 3: next tap wraps to zero, phase wraps at the length
		add_cfg(CFG_SAMPLES, 43'd3);
		add_item(ACT_TICK, 0, 0, 0, 1, 16'h8000);
		add_item(ACT_TICK, 0, 0, 0, 0, '0);
		// length 1: both taps are the same sample
		add_cfg(CFG_SAMPLES, 43'd1);
		add_item(ACT_TICK, 7, 0, 0, 1, 16'hFFFF);
		add_item(ACT_TICK, 7, 0, 0, 1, 16'hFFFF);
		// length zero clamps to one
		add_cfg(CFG_SAMPLES, 43'd0);
		add_item(ACT_TICK, 0, 0, 0, 1, 16'h0000);
		// oversized length clamps to the table depth; full-scale step
		add_cfg(CFG_SAMPLES, 43'd4095);
		add_cfg(CFG_PHASE_INC, 43'h7FF_FFFF_FFFF);
		add_item(ACT_TICK, 0, 0, 0, 0, '0);
		add_item(ACT_TICK, 0, 0, 0, 0, '0);
		// jump to the last position so the next tap wraps to zero
		add_cfg(CFG_PHASE_INC, 43'h7FF_0000_0000);
		add_item(ACT_TICK, 0, 0, 0, 0, '0);
		add_item(ACT_TICK, 7, 0, 0, 0, '0);

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				settle();
				write_reg(rows[i].reg_sel, rows[i].reg_val);
			end else begin
				offer(rows[i].act, rows[i].tbl, rows[i].idx, rows[i].val, rows[i].known,
					rows[i].known_out);
			end
		end

		// random part: one register setting per phase, phase carried over
		for (int p = 0; p < 9; p++) begin
			settle();
			r64 = {$urandom, $urandom};
			case (p)
				0: begin inc_v = 43'(r64[31:0]);                          len_v = 43'd8;    end
				1: begin inc_v = '0;            len_v = r64[42:0]; len_v[LEN_W-1:0] = 12'd2048; end
				2: begin inc_v = 43'h7FF_FFFF_FFFF;                       len_v = 43'd16;   end
				3: begin inc_v = r64[42:0];                               len_v = 43'd1;    end
				4: begin inc_v = {11'($urandom_range(2)), r64[31:0]};     len_v = 43'd5;    end
				5: begin inc_v = {11'($urandom_range(3)), r64[31:0]};     len_v = 43'd2048; end
				6: begin inc_v = {11'($urandom_range(3)), r64[31:0]};     len_v = 43'd0;    end
				7: begin inc_v = {11'($urandom_range(1)), r64[31:0]};     len_v = 43'd4095; end
				default: begin
					inc_v = {11'($urandom_range(63)), r64[31:0]};
					len_v = 43'($urandom_range(64, 1));
				end
			endcase
			write_reg(CFG_PHASE_INC, inc_v);
			write_reg(CFG_SAMPLES, len_v);
			no_gaps = (p == 4);
			random_phase(PHASE_ITEMS, p == 5);
		end
		settle();
		no_gaps = 1'b0;

		$display("Summary: %0d sample writes and %0d ticks over %0d register writes",
			writes_sent, ticks_sent, reg_writes);
		$display("Lengths 0, 1, small, full and clamped; steps 0, fractional and full scale");
		if (fail_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches", fail_cnt);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/wolc_pkg.sv
hdl/wolc_wave_ram.sv
hdl/wolc_out_fifo.sv
hdl/wavetable_oscillator_lerp_core.sv
sim/wavetable_oscillator_lerp_core_tb.sv
